// ----- sv/kvt_pkg.sv -----
// Shared types and constants for the key/value line tokenizer.
// No dependencies; used by the channel interfaces and the top level.
package kvt_pkg;

  localparam logic [7:0] TOKEN_LIMIT_RST = 8'd64;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [2:0] {
    ROLE_BLANK   = 3'd0,
    ROLE_KEY     = 3'd1,
    ROLE_EQUALS  = 3'd2,
    ROLE_OPEN    = 3'd3,
    ROLE_VALUE   = 3'd4,
    ROLE_ESC     = 3'd5,
    ROLE_CLOSE   = 3'd6,
    ROLE_IGNORED = 3'd7
  } role_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_MANY  = 2'd1,
    STAT_BAD_ESC   = 2'd2,
    STAT_OPEN_QUOTE = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    MODE_BETWEEN  = 6'b000001,
    MODE_KEY      = 6'b000010,
    MODE_AFTER_EQ = 6'b000100,
    MODE_BARE     = 6'b001000,
    MODE_QUOTED   = 6'b010000,
    MODE_ESCAPE   = 6'b100000
  } mode_t;

  typedef struct packed {
    role_t      role;
    logic [7:0] token_index;
    logic       token_start;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       line_done;
    status_t    status;
    logic [7:0] token_count;
  } res_t;

endpackage

// ----- sv/kvt_if.sv -----
// Valid/ready channel interfaces for the tokenizer: input bytes, results,
// and the configuration write channel. Depends on kvt_pkg.
interface kvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;
  modport source (output valid, ch, line_end, input ready);
  modport sink   (input valid, ch, line_end, output ready);
endinterface

interface kvt_out_if;
  logic              valid;
  logic              ready;
  kvt_pkg::role_t    role;
  logic [7:0]        token_index;
  logic              token_start;
  logic [7:0]        data_byte;
  logic              data_valid;
  logic              line_done;
  kvt_pkg::status_t  status;
  logic [7:0]        token_count;
  modport source (output valid, role, token_index, token_start, data_byte, data_valid,
                  line_done, status, token_count, input ready);
  modport sink   (input valid, role, token_index, token_start, data_byte, data_valid,
                  line_done, status, token_count, output ready);
endinterface

interface kvt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- sv/key_value_line_tokenizer.sv -----
// Key[=value] line tokenizer: top level with input register, scan logic
// and result register. Depends on kvt_pkg and the interfaces in kvt_if.sv.
//
// Usage:
//   in_chan  - one item per transfer: a byte of the line (ch), or line_end
//              set to close the line. The block takes one item every cycle while out_chan takes its results.
//   out_chan - exactly one result per input item, in order: role, token
//              index, resolved key/value byte, and status/count at line end.
//   cfg_chan - writes the token limit (reset 64); write only while the block
//              is idle. Always ready.
// Each item passes through the input register and then the result register
// before its result is offered on out_chan.
// Throughput: one item per cycle while out_chan takes each result, set by the
// combinational scan-mode update between the input register and the result register.
// Stall: when out_chan is held off, the result register holds, the input
// register fills, and in_chan.ready drops until the result is taken.
// Reset: synchronous active-low rst_n empties both registers and returns
// the scanner to the between-tokens state with no tokens and no error.
// A line_end item returns the scanner to that same state for the next line.
module key_value_line_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  kvt_in_if.sink     in_chan,
  kvt_out_if.source  out_chan,
  kvt_cfg_if.sink    cfg_chan
);

  // input register
  logic             s1_valid_r;
  logic [7:0]       s1_ch_r;
  logic             s1_end_r;

  // scan state
  kvt_pkg::mode_t   mode_r, mode_nxt;
  logic [7:0]       tokens_r, tokens_nxt;
  kvt_pkg::status_t err_r, err_nxt;
  logic [7:0]       tok_limit_r;

  // result register
  logic             out_valid_r;
  kvt_pkg::res_t    res_r, res_nxt;

  logic             advance;
  logic             blank;
  logic [7:0]       cur_idx;

  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;
  assign cfg_chan.ready = 1'b1;

  assign blank   = (s1_ch_r == kvt_pkg::CH_SPACE) || (s1_ch_r == kvt_pkg::CH_TAB);
  assign cur_idx = (tokens_r == 8'd0) ? 8'd0 : tokens_r - 8'd1;

  always_comb begin
    res_nxt    = '0;
    res_nxt.role = kvt_pkg::ROLE_IGNORED;
    mode_nxt   = mode_r;
    tokens_nxt = tokens_r;
    err_nxt    = err_r;
    if (s1_end_r) begin
      res_nxt.role        = kvt_pkg::ROLE_BLANK;
      res_nxt.line_done   = 1'b1;
      res_nxt.token_count = tokens_r;
      if (err_r != kvt_pkg::STAT_OK) begin
        res_nxt.status = err_r;
      end else if (mode_r == kvt_pkg::MODE_QUOTED || mode_r == kvt_pkg::MODE_ESCAPE) begin
        res_nxt.status = kvt_pkg::STAT_OPEN_QUOTE;
      end
      mode_nxt   = kvt_pkg::MODE_BETWEEN;
      tokens_nxt = 8'd0;
      err_nxt    = kvt_pkg::STAT_OK;
    end else if (err_r == kvt_pkg::STAT_OK) begin
      unique case (mode_r)
        kvt_pkg::MODE_KEY: begin
          if (blank) begin
            res_nxt.role = kvt_pkg::ROLE_BLANK;
            mode_nxt     = kvt_pkg::MODE_BETWEEN;
          end else if (s1_ch_r == kvt_pkg::CH_EQUALS) begin
            res_nxt.role        = kvt_pkg::ROLE_EQUALS;
            res_nxt.token_index = cur_idx;
            mode_nxt            = kvt_pkg::MODE_AFTER_EQ;
          end else begin
            res_nxt.role        = kvt_pkg::ROLE_KEY;
            res_nxt.token_index = cur_idx;
            res_nxt.data_byte   = s1_ch_r;
            res_nxt.data_valid  = 1'b1;
          end
        end
        kvt_pkg::MODE_AFTER_EQ: begin
          if (blank) begin
            res_nxt.role = kvt_pkg::ROLE_BLANK;
            mode_nxt     = kvt_pkg::MODE_BETWEEN;
          end else if (s1_ch_r == kvt_pkg::CH_QUOTE) begin
            res_nxt.role        = kvt_pkg::ROLE_OPEN;
            res_nxt.token_index = cur_idx;
            mode_nxt            = kvt_pkg::MODE_QUOTED;
          end else begin
            res_nxt.role        = kvt_pkg::ROLE_VALUE;
            res_nxt.token_index = cur_idx;
            res_nxt.data_byte   = s1_ch_r;
            res_nxt.data_valid  = 1'b1;
            mode_nxt            = kvt_pkg::MODE_BARE;
          end
        end
        kvt_pkg::MODE_BARE: begin
          if (blank) begin
            res_nxt.role = kvt_pkg::ROLE_BLANK;
            mode_nxt     = kvt_pkg::MODE_BETWEEN;
          end else begin
            res_nxt.role        = kvt_pkg::ROLE_VALUE;
            res_nxt.token_index = cur_idx;
            res_nxt.data_byte   = s1_ch_r;
            res_nxt.data_valid  = 1'b1;
          end
        end
        kvt_pkg::MODE_QUOTED: begin
          res_nxt.token_index = cur_idx;
          if (s1_ch_r == kvt_pkg::CH_BSLASH) begin
            res_nxt.role = kvt_pkg::ROLE_ESC;
            mode_nxt     = kvt_pkg::MODE_ESCAPE;
          end else if (s1_ch_r == kvt_pkg::CH_QUOTE) begin
            res_nxt.role = kvt_pkg::ROLE_CLOSE;
            mode_nxt     = kvt_pkg::MODE_BETWEEN;
          end else begin
            res_nxt.role       = kvt_pkg::ROLE_VALUE;
            res_nxt.data_byte  = s1_ch_r;
            res_nxt.data_valid = 1'b1;
          end
        end
        kvt_pkg::MODE_ESCAPE: begin
          if (s1_ch_r == kvt_pkg::CH_QUOTE || s1_ch_r == kvt_pkg::CH_BSLASH) begin
            res_nxt.role        = kvt_pkg::ROLE_VALUE;
            res_nxt.token_index = cur_idx;
            res_nxt.data_byte   = s1_ch_r;
            res_nxt.data_valid  = 1'b1;
            mode_nxt            = kvt_pkg::MODE_QUOTED;
          end else begin
            // drop the byte and hold the error to line end
            err_nxt = kvt_pkg::STAT_BAD_ESC;
          end
        end
        default: begin
          // between tokens: a non-blank byte opens a token if the limit allows
          mode_nxt = kvt_pkg::MODE_BETWEEN;
          if (blank) begin
            res_nxt.role = kvt_pkg::ROLE_BLANK;
          end else if (tokens_r >= tok_limit_r) begin
            err_nxt = kvt_pkg::STAT_TOO_MANY;
          end else begin
            res_nxt.token_index = tokens_r;
            res_nxt.token_start = 1'b1;
            tokens_nxt          = tokens_r + 8'd1;
            if (s1_ch_r == kvt_pkg::CH_EQUALS) begin
              res_nxt.role = kvt_pkg::ROLE_EQUALS;
              mode_nxt     = kvt_pkg::MODE_AFTER_EQ;
            end else begin
              res_nxt.role       = kvt_pkg::ROLE_KEY;
              res_nxt.data_byte  = s1_ch_r;
              res_nxt.data_valid = 1'b1;
              mode_nxt           = kvt_pkg::MODE_KEY;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      mode_r       <= kvt_pkg::MODE_BETWEEN;
      tokens_r     <= 8'd0;
      err_r        <= kvt_pkg::STAT_OK;
      tok_limit_r  <= kvt_pkg::TOKEN_LIMIT_RST;
    end else begin
      if (cfg_chan.valid) begin
        tok_limit_r <= cfg_chan.data;
      end
      if (in_chan.ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        mode_r      <= mode_nxt;
        tokens_r    <= tokens_nxt;
        err_r       <= err_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_ch_r  <= in_chan.ch;
      s1_end_r <= in_chan.line_end;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.role        = res_r.role;
  assign out_chan.token_index = res_r.token_index;
  assign out_chan.token_start = res_r.token_start;
  assign out_chan.data_byte   = res_r.data_byte;
  assign out_chan.data_valid  = res_r.data_valid;
  assign out_chan.line_done   = res_r.line_done;
  assign out_chan.status      = res_r.status;
  assign out_chan.token_count = res_r.token_count;

  // a line end always leaves a clean scanner for the next line
  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_end_r |=> tokens_r == 8'd0 && err_r == kvt_pkg::STAT_OK &&
                            mode_r == kvt_pkg::MODE_BETWEEN)
    else $error("scanner state not cleared after line end");

  // an error sticks until the line ends
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != kvt_pkg::STAT_OK && !(advance && s1_end_r) |=> err_r == $past(err_r))
    else $error("error code changed before line end");

  // only key and value bytes carry data
  a_data_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.data_valid |->
      res_r.role == kvt_pkg::ROLE_KEY || res_r.role == kvt_pkg::ROLE_VALUE)
    else $error("data byte on a role that carries none");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for key_value_line_tokenizer: a clocked driver feeds queued line bytes,
// a monitor checks every result against a bench-side scanner. Depends on kvt_pkg, kvt_if.sv.
module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PRESSURE_HOLD  = 400;
  localparam int unsigned PHASE_ITEMS    = 80;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } line_item_t;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_t;

  logic clk;
  logic rst_n;

  kvt_in_if  in_bus ();
  kvt_out_if res_bus ();
  kvt_cfg_if cfg_bus ();

  key_value_line_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (res_bus),
    .cfg_chan (cfg_bus)
  );

  // bench copy of the scanner state and the token limit
  kvt_pkg::mode_t   scan_mode;
  logic [7:0]       tok_seen;
  kvt_pkg::status_t scan_err;
  logic [7:0]       limit_cfg;

  line_item_t     pending_bytes[$];
  kvt_pkg::res_t  expected_results[$];
  int unsigned queued_items;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned lines_closed;
  int unsigned status_seen[4];
  int unsigned limit_writes;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rx_cycle;
  int unsigned hold_left;
  rx_pattern_t rx_mode;
  bit          pressure_req;
  bit          pressure_done;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic kvt_pkg::res_t scan_byte(input logic [7:0] c, input logic eol);
    kvt_pkg::res_t r;
    logic [7:0]    cur;
    logic          blank;
    r = '0;
    r.role = kvt_pkg::ROLE_IGNORED;
    cur = (tok_seen == 8'd0) ? 8'd0 : tok_seen - 8'd1;
    blank = (c == kvt_pkg::CH_SPACE) || (c == kvt_pkg::CH_TAB);
    if (eol) begin
      r.role = kvt_pkg::ROLE_BLANK;
      r.line_done = 1'b1;
      r.token_count = tok_seen;
      if (scan_err != kvt_pkg::STAT_OK)
        r.status = scan_err;
      else if (scan_mode == kvt_pkg::MODE_QUOTED || scan_mode == kvt_pkg::MODE_ESCAPE)
        r.status = kvt_pkg::STAT_OPEN_QUOTE;
      scan_mode = kvt_pkg::MODE_BETWEEN;
      tok_seen = 8'd0;
      scan_err = kvt_pkg::STAT_OK;
    end else if (scan_err == kvt_pkg::STAT_OK) begin
      case (scan_mode)
        kvt_pkg::MODE_KEY: begin
          if (blank) begin
            r.role = kvt_pkg::ROLE_BLANK;
            scan_mode = kvt_pkg::MODE_BETWEEN;
          end else if (c == kvt_pkg::CH_EQUALS) begin
            r.role = kvt_pkg::ROLE_EQUALS;
            r.token_index = cur;
            scan_mode = kvt_pkg::MODE_AFTER_EQ;
          end else begin
            r.role = kvt_pkg::ROLE_KEY;
            r.token_index = cur;
            r.data_byte = c;
            r.data_valid = 1'b1;
          end
        end
        kvt_pkg::MODE_AFTER_EQ: begin
          if (blank) begin
            r.role = kvt_pkg::ROLE_BLANK;
            scan_mode = kvt_pkg::MODE_BETWEEN;
          end else if (c == kvt_pkg::CH_QUOTE) begin
            r.role = kvt_pkg::ROLE_OPEN;
            r.token_index = cur;
            scan_mode = kvt_pkg::MODE_QUOTED;
          end else begin
            r.role = kvt_pkg::ROLE_VALUE;
            r.token_index = cur;
            r.data_byte = c;
            r.data_valid = 1'b1;
            scan_mode = kvt_pkg::MODE_BARE;
          end
        end
        kvt_pkg::MODE_BARE: begin
          if (blank) begin
            r.role = kvt_pkg::ROLE_BLANK;
            scan_mode = kvt_pkg::MODE_BETWEEN;
          end else begin
            r.role = kvt_pkg::ROLE_VALUE;
            r.token_index = cur;
            r.data_byte = c;
            r.data_valid = 1'b1;
          end
        end
        kvt_pkg::MODE_QUOTED: begin
          r.token_index = cur;
          if (c == kvt_pkg::CH_BSLASH) begin
            r.role = kvt_pkg::ROLE_ESC;
            scan_mode = kvt_pkg::MODE_ESCAPE;
          end else if (c == kvt_pkg::CH_QUOTE) begin
            r.role = kvt_pkg::ROLE_CLOSE;
            scan_mode = kvt_pkg::MODE_BETWEEN;
          end else begin
            r.role = kvt_pkg::ROLE_VALUE;
            r.data_byte = c;
            r.data_valid = 1'b1;
          end
        end
        kvt_pkg::MODE_ESCAPE: begin
          if (c == kvt_pkg::CH_QUOTE || c == kvt_pkg::CH_BSLASH) begin
            r.role = kvt_pkg::ROLE_VALUE;
            r.token_index = cur;
            r.data_byte = c;
            r.data_valid = 1'b1;
            scan_mode = kvt_pkg::MODE_QUOTED;
          end else begin
            scan_err = kvt_pkg::STAT_BAD_ESC;
          end
        end
        default: begin
          scan_mode = kvt_pkg::MODE_BETWEEN;
          if (blank) begin
            r.role = kvt_pkg::ROLE_BLANK;
          end else if (tok_seen >= limit_cfg) begin
            scan_err = kvt_pkg::STAT_TOO_MANY;
          end else begin
            r.token_index = tok_seen;
            r.token_start = 1'b1;
            tok_seen = tok_seen + 8'd1;
            if (c == kvt_pkg::CH_EQUALS) begin
              r.role = kvt_pkg::ROLE_EQUALS;
              scan_mode = kvt_pkg::MODE_AFTER_EQ;
            end else begin
              r.role = kvt_pkg::ROLE_KEY;
              r.data_byte = c;
              r.data_valid = 1'b1;
              scan_mode = kvt_pkg::MODE_KEY;
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic string show(input kvt_pkg::res_t r);
    return $sformatf({"role=%0d idx=%0d start=%0b data=%02h dv=%0b ",
                      "done=%0b status=%0d count=%0d"},
                     r.role, r.token_index, r.token_start, r.data_byte, r.data_valid,
                     r.line_done, r.status, r.token_count);
  endfunction

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(0, 1) == 0) ? kvt_pkg::CH_SPACE : kvt_pkg::CH_TAB;
  endfunction

  function automatic logic [7:0] rand_solid();
    logic [7:0] b;
    do b = 8'($urandom); while (b == kvt_pkg::CH_SPACE || b == kvt_pkg::CH_TAB);
    return b;
  endfunction

  function automatic logic [7:0] rand_key_byte();
    logic [7:0] b;
    do b = rand_solid(); while (b == kvt_pkg::CH_EQUALS);
    return b;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    line_item_t it;
    it.ch  = b;
    it.eol = 1'b0;
    pending_bytes = {pending_bytes, it};
    queued_items++;
  endtask

  task automatic push_end();
    line_item_t it;
    it.ch  = 8'($urandom);
    it.eol = 1'b1;
    pending_bytes = {pending_bytes, it};
    queued_items++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i]);
  endtask

  // Mostly well-formed lines with random content; some noise, some broken tails.
  task automatic gen_line();
    int unsigned kind;
    int unsigned ntok;
    int unsigned vkind;
    logic [7:0]  b;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom));
    end else begin
      if ($urandom_range(0, 3) == 0)
        push_byte(rand_blank());
      ntok = $urandom_range(0, 6);
      for (int t = 0; t < ntok; t++) begin
        vkind = $urandom_range(0, 2);
        repeat ($urandom_range((vkind == 0) ? 1 : 0, 4)) push_byte(rand_key_byte());
        if (vkind == 1) begin
          push_byte(kvt_pkg::CH_EQUALS);
          repeat ($urandom_range(0, 4)) push_byte(rand_solid());
        end else if (vkind == 2) begin
          push_byte(kvt_pkg::CH_EQUALS);
          push_byte(kvt_pkg::CH_QUOTE);
          repeat ($urandom_range(0, 5)) begin
            b = 8'($urandom);
            if (b == kvt_pkg::CH_QUOTE || b == kvt_pkg::CH_BSLASH)
              push_byte(kvt_pkg::CH_BSLASH);
            push_byte(b);
          end
          push_byte(kvt_pkg::CH_QUOTE);
        end
        // a closing quote may run straight into the next token
        if (!(vkind == 2 && $urandom_range(0, 2) == 0))
          repeat ($urandom_range(1, 2)) push_byte(rand_blank());
      end
      if (kind == 1) begin
        push_byte(rand_key_byte());
        push_byte(kvt_pkg::CH_EQUALS);
        push_byte(kvt_pkg::CH_QUOTE);
        push_byte(rand_key_byte());
        if ($urandom_range(0, 1) == 0) begin
          push_byte(kvt_pkg::CH_BSLASH);
          do b = 8'($urandom); while (b == kvt_pkg::CH_QUOTE || b == kvt_pkg::CH_BSLASH);
          push_byte(b);
          repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
        end
      end
    end
    push_end();
  endtask

  // Wait until every queued byte is taken and every result has come back.
  task automatic drain();
    while (items_sent != queued_items || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    cfg_bus.data  <= v;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    limit_cfg = v;
    limit_writes++;
  endtask

  // Sender: bursts of random length with random gaps; predict on each transfer.
  always @(posedge clk) begin : send_bytes
    line_item_t    nxt;
    logic          sent;
    kvt_pkg::res_t pred;
    if (!rst_n) begin
      in_bus.valid    <= 1'b0;
      in_bus.ch       <= 8'd0;
      in_bus.line_end <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      scan_mode = kvt_pkg::MODE_BETWEEN;
      tok_seen = 8'd0;
      scan_err = kvt_pkg::STAT_OK;
    end else begin
      sent = in_bus.valid && in_bus.ready;
      if (sent) begin
        pred = scan_byte(in_bus.ch, in_bus.line_end);
        expected_results = {expected_results, pred};
        items_sent++;
      end
      if (sent || !in_bus.valid) begin
        if (gap_left != 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          nxt = pending_bytes.pop_front();
          in_bus.ch       <= nxt.ch;
          in_bus.line_end <= nxt.eol;
          in_bus.valid    <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern redrawn at random periodically; one long hold-off on request.
  always @(posedge clk) begin : take_results
    logic rdy;
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      rx_cycle = 0;
      hold_left = 0;
      rx_mode = RX_FREE;
      pressure_done = 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 80 == 0)
        rx_mode = rx_pattern_t'($urandom_range(0, 3));
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (pressure_req && !pressure_done) begin
        pressure_done = 1'b1;
        hold_left = PRESSURE_HOLD;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   rdy = 1'b1;
          RX_COIN:   rdy = 1'($urandom_range(0, 1));
          RX_SPARSE: rdy = (rx_cycle % 4) == 0;
          default:   rdy = $urandom_range(0, 6) != 0;
        endcase
      end
      res_bus.ready <= rdy;
    end
  end

  always @(posedge clk) begin : check_results
    kvt_pkg::res_t got;
    kvt_pkg::res_t want;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      got.role        = res_bus.role;
      got.token_index = res_bus.token_index;
      got.token_start = res_bus.token_start;
      got.data_byte   = res_bus.data_byte;
      got.data_valid  = res_bus.data_valid;
      got.line_done   = res_bus.line_done;
      got.status      = res_bus.status;
      got.token_count = res_bus.token_count;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: %s", show(got));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.line_done) begin
          lines_closed++;
          status_seen[want.status]++;
        end
        if (got.role !== want.role || got.token_index !== want.token_index ||
            got.token_start !== want.token_start || got.data_byte !== want.data_byte ||
            got.data_valid !== want.data_valid || got.line_done !== want.line_done ||
            got.status !== want.status || got.token_count !== want.token_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch on result %0d", results_checked - 1);
            $display("  expected %s", show(want));
            $display("  actual   %s", show(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_bus.valid && in_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin : run
    logic [7:0]  limits[7];
    int unsigned phase_start;
    limit_cfg = kvt_pkg::TOKEN_LIMIT_RST;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = 8'd0;
    pressure_req = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty key, bare value, escaped backslash, token straight after a close quote
    push_text("=x a=\"\\\\\"z");
    push_end();
    // extreme bytes, quote inside a key, equals inside a bare value, quote opening a key
    push_byte(8'h00);
    push_text("\"=");
    push_byte(8'hFF);
    push_text("=\t\"");
    push_end();
    // bad escape, then the rest of the line ignored
    push_text("a=\"\\q");
    push_end();
    // line ends inside quotes just after an escaped quote
    push_text("b=\"\\\"");
    push_end();

    limits = '{8'd0, 8'd1, 8'd3, 8'd255, 8'd2, 8'd0, 8'd64};
    limits[5] = 8'($urandom_range(4, 254));
    foreach (limits[p]) begin
      drain();
      write_limit(limits[p]);
      phase_start = queued_items;
      if (limits[p] == 8'd255) begin
        // one line past the widest limit: 255 tokens then a rejected one
        repeat (256) begin
          push_byte(rand_key_byte());
          push_byte(rand_blank());
        end
        push_end();
      end
      if (limits[p] == kvt_pkg::TOKEN_LIMIT_RST)
        pressure_req = 1'b1;
      while (queued_items - phase_start < PHASE_ITEMS)
        gen_line();
    end

    drain();
    repeat (6) @(posedge clk);
    $display("covered %0d bytes in %0d lines over %0d token limits, %0d results checked",
             items_sent, lines_closed, limit_writes, results_checked);
    $display("line status: ok %0d, too many %0d, bad escape %0d, open quote %0d",
             status_seen[kvt_pkg::STAT_OK], status_seen[kvt_pkg::STAT_TOO_MANY],
             status_seen[kvt_pkg::STAT_BAD_ESC], status_seen[kvt_pkg::STAT_OPEN_QUOTE]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_results.size());
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- key_value_line_tokenizer.f -----
sv/kvt_pkg.sv
sv/kvt_if.sv
sv/key_value_line_tokenizer.sv
tb/testbench.sv
